// ----- hdl/ptd_pkg.sv -----
package ptd_pkg;

    localparam int SLOTS_DEF  = 16;
    localparam int RESULT_CAP = 16;
    localparam int CAP_W      = $clog2(RESULT_CAP + 1);

    localparam logic [1:0] CMD_TICK        = 2'd0;
    localparam logic [1:0] CMD_SUBSCRIBE   = 2'd1;
    localparam logic [1:0] CMD_UNSUBSCRIBE = 2'd2;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    // One subscription slot as held in the slot memory.
    typedef struct packed {
        logic [15:0] cport;
        logic [15:0] mtype;
        logic [15:0] rate;
        logic [15:0] rate_left;
        logic [15:0] ticks_left;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

endpackage

// ----- hdl/periodic_tick_dispatcher.sv -----
// Periodic tick dispatcher: a table of SLOTS subscriptions driven by commands.
// Input channel s_axis: tuser carries the command (tick, subscribe, unsubscribe),
// tdata the client port, message type, rate and expiry count of a subscription.
// Output channel m_axis: tuser is set on a delivery to a client; tdata carries
// the status, destination port and type, and the tick value. tlast marks the
// final result belonging to one command.
// Tick, subscribe and unsubscribe are served by one sequencer that walks the slots
// in index order, with a memory read, then update and write-back, for each slot
// on the single port pair of the slot memory. A tick walks every slot; subscribe
// and unsubscribe stop at the first free or matching slot. Other command codes
// answer with an ok status without a walk. One command is in work at a time;
// s_axis_tready is high only between commands, while a previous result may still
// sit in the output register.
// A tick yields one result per delivering slot, at most sixteen, in slot order,
// or a single empty result when no slot delivers.
// Reset empties the table and clears the tick counter; no clearing pass is
// needed. When the receiver stalls, the walk pauses until the output register
// frees, so no result is lost.
module periodic_tick_dispatcher #(
    parameter int SLOTS = ptd_pkg::SLOTS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,  // client_port, message_type, rate, count
    input  logic [1:0]  s_axis_tuser,  // cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [71:0] m_axis_tdata,  // status, dest_port, dest_type, tick_value, zero pad
    output logic [0:0]  m_axis_tuser,  // is_delivery
    output logic        m_axis_tlast
);

    import ptd_pkg::*;

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_READ  = 5'b00010,
        ST_PROC  = 5'b00100,
        ST_FLUSH = 5'b01000,
        ST_STAT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [1:0]          cmd_reg, cmd_next;
    logic [1:0]          status_reg, status_next;
    logic [31:0]         tick_reg, tick_next;
    logic [CAP_W-1:0]    n_reg, n_next;
    logic [SLOTS-1:0]    valid_reg, valid_next;
    logic                pend_valid_reg, pend_valid_next;
    logic                out_valid_reg, out_valid_next;

    logic [15:0]         port_reg, port_next;
    logic [15:0]         type_reg, type_next;
    logic [15:0]         rate_reg, rate_next;
    logic [15:0]         count_reg, count_next;
    logic [15:0]         pend_port_reg, pend_port_next;
    logic [15:0]         pend_type_reg, pend_type_next;

    logic                out_deliv_reg, out_deliv_next;
    logic [1:0]          out_status_reg, out_status_next;
    logic [15:0]         out_port_reg, out_port_next;
    logic [15:0]         out_type_reg, out_type_next;
    logic [31:0]         out_tick_reg, out_tick_next;
    logic                out_last_reg, out_last_next;

    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    slot_entry_t         entry;
    slot_entry_t         wentry;
    logic                out_busy;
    logic                out_load;
    logic                slot_v;
    logic                done;
    logic                deliver;
    logic [15:0]         rl_dec;

    ptd_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (wentry),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign entry    = slot_entry_t'(ram_rdata);
    assign out_busy = out_valid_reg && !m_axis_tready;
    assign slot_v   = valid_reg[idx_reg];
    assign rl_dec   = entry.rate_left - 16'd1;

    always_comb
    begin
        state_next      = state_reg;
        idx_next        = idx_reg;
        cmd_next        = cmd_reg;
        status_next     = status_reg;
        tick_next       = tick_reg;
        n_next          = n_reg;
        valid_next      = valid_reg;
        pend_valid_next = pend_valid_reg;
        pend_port_next  = pend_port_reg;
        pend_type_next  = pend_type_reg;
        port_next       = port_reg;
        type_next       = type_reg;
        rate_next       = rate_reg;
        count_next      = count_reg;
        out_load        = 1'b0;
        out_deliv_next  = out_deliv_reg;
        out_status_next = out_status_reg;
        out_port_next   = out_port_reg;
        out_type_next   = out_type_reg;
        out_tick_next   = out_tick_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_re          = 1'b0;
        wentry          = entry;
        done            = 1'b0;
        deliver         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd_next        = s_axis_tuser;
                    port_next       = s_axis_tdata[15:0];
                    type_next       = s_axis_tdata[31:16];
                    rate_next       = s_axis_tdata[47:32];
                    count_next      = s_axis_tdata[63:48];
                    idx_next        = '0;
                    n_next          = '0;
                    pend_valid_next = 1'b0;
                    case (s_axis_tuser)
                        CMD_TICK:
                        begin
                            tick_next  = tick_reg + 32'd1;
                            state_next = ST_READ;
                        end
                        CMD_SUBSCRIBE:
                        begin
                            status_next = STATUS_FULL;
                            state_next  = ST_READ;
                        end
                        CMD_UNSUBSCRIBE:
                        begin
                            status_next = STATUS_NOT_FOUND;
                            state_next  = ST_READ;
                        end
                        default:
                        begin
                            status_next = STATUS_OK;
                            state_next  = ST_STAT;
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                ram_re     = 1'b1;
                state_next = ST_PROC;
            end

            ST_PROC:
            begin
                if (!out_busy)
                begin
                    case (cmd_reg)
                        CMD_TICK:
                        begin
                            if (slot_v)
                            begin
                                // Expiry and rate steps both act before the slot retires.
                                if (entry.ticks_left != 16'd0)
                                begin
                                    wentry.ticks_left = entry.ticks_left - 16'd1;
                                end
                                if (entry.ticks_left == 16'd1)
                                begin
                                    valid_next[idx_reg] = 1'b0;
                                end
                                deliver          = (rl_dec == 16'd0);
                                wentry.rate_left = deliver ? entry.rate : rl_dec;
                                ram_we           = 1'b1;
                                if (deliver && (n_reg < CAP_W'(RESULT_CAP)))
                                begin
                                    n_next          = n_reg + CAP_W'(1);
                                    pend_valid_next = 1'b1;
                                    pend_port_next  = entry.cport;
                                    pend_type_next  = entry.mtype;
                                    // The held delivery is now known not to be the last.
                                    if (pend_valid_reg)
                                    begin
                                        out_load        = 1'b1;
                                        out_deliv_next  = 1'b1;
                                        out_status_next = STATUS_OK;
                                        out_port_next   = pend_port_reg;
                                        out_type_next   = pend_type_reg;
                                        out_tick_next   = tick_reg;
                                        out_last_next   = 1'b0;
                                    end
                                end
                            end
                        end
                        CMD_SUBSCRIBE:
                        begin
                            if (!slot_v)
                            begin
                                wentry.cport        = port_reg;
                                wentry.mtype        = type_reg;
                                wentry.rate         = rate_reg;
                                wentry.rate_left    = rate_reg;
                                wentry.ticks_left   = count_reg;
                                ram_we              = 1'b1;
                                valid_next[idx_reg] = 1'b1;
                                status_next         = STATUS_OK;
                                done                = 1'b1;
                            end
                        end
                        CMD_UNSUBSCRIBE:
                        begin
                            if (slot_v && (entry.cport == port_reg) &&
                                (entry.mtype == type_reg) && (entry.rate == rate_reg))
                            begin
                                valid_next[idx_reg] = 1'b0;
                                status_next         = STATUS_OK;
                                done                = 1'b1;
                            end
                        end
                        default:
                        begin
                            done = 1'b1;
                        end
                    endcase

                    if (done)
                    begin
                        state_next = ST_STAT;
                    end
                    else if (idx_reg == IDX_W'(SLOTS - 1))
                    begin
                        state_next = (cmd_reg == CMD_TICK) ? ST_FLUSH : ST_STAT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = ST_READ;
                    end
                end
            end

            ST_FLUSH:
            begin
                if (!out_busy)
                begin
                    out_load        = 1'b1;
                    out_deliv_next  = pend_valid_reg;
                    out_status_next = STATUS_OK;
                    out_port_next   = pend_valid_reg ? pend_port_reg : 16'd0;
                    out_type_next   = pend_valid_reg ? pend_type_reg : 16'd0;
                    out_tick_next   = tick_reg;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = ST_IDLE;
                end
            end

            ST_STAT:
            begin
                if (!out_busy)
                begin
                    out_load        = 1'b1;
                    out_deliv_next  = 1'b0;
                    out_status_next = status_reg;
                    out_port_next   = 16'd0;
                    out_type_next   = 16'd0;
                    out_tick_next   = 32'd0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            idx_reg        <= '0;
            cmd_reg        <= CMD_TICK;
            status_reg     <= STATUS_OK;
            tick_reg       <= '0;
            n_reg          <= '0;
            valid_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            idx_reg        <= idx_next;
            cmd_reg        <= cmd_next;
            status_reg     <= status_next;
            tick_reg       <= tick_next;
            n_reg          <= n_next;
            valid_reg      <= valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        port_reg       <= port_next;
        type_reg       <= type_next;
        rate_reg       <= rate_next;
        count_reg      <= count_next;
        pend_port_reg  <= pend_port_next;
        pend_type_reg  <= pend_type_next;
        out_deliv_reg  <= out_deliv_next;
        out_status_reg <= out_status_next;
        out_port_reg   <= out_port_next;
        out_type_reg   <= out_type_next;
        out_tick_reg   <= out_tick_next;
        out_last_reg   <= out_last_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_deliv_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {6'd0, out_tick_reg, out_type_reg, out_port_reg, out_status_reg};

    // A tick command advances the counter by exactly one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_TICK))
        |=> (tick_reg == $past(tick_reg) + 32'd1))
        else $error("tick counter did not advance on a tick");

    // No delivery is held back once the sequencer is back between commands.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> !pend_valid_reg)
        else $error("pending delivery left behind after a command");

    // The number of deliveries in one tick never exceeds the result cap.
    assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= CAP_W'(RESULT_CAP))
        else $error("delivery count beyond cap");

    // A result is loaded only while the output register is free or draining.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !m_axis_tready) |=> $stable(m_axis_tdata) && out_valid_reg)
        else $error("output register overwritten while stalled");

    // Ticks are the only command that can put a result out with last clear.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (out_deliv_reg && (cmd_reg == CMD_TICK)))
        else $error("non-final result outside a tick");

endmodule

// ----- hdl/ptd_ram.sv -----
module ptd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import ptd_pkg::*;

    localparam int NUM_SLOTS    = SLOTS_DEF;
    localparam int DRAIN_CYCLES = 2 * NUM_SLOTS + 8;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    // The block answers any code outside the three commands with a plain ok.
    localparam logic [1:0] CMD_RESERVED = 2'd3;

    typedef struct packed {
        logic        is_delivery;
        logic [1:0]  status;
        logic [15:0] dest_port;
        logic [15:0] dest_type;
        logic [31:0] tick_value;
        logic        last;
    } tick_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;
    logic [1:0]  s_axis_tuser = CMD_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [71:0] m_axis_tdata;
    logic [0:0]  m_axis_tuser;
    logic        m_axis_tlast;

    // Shadow copy of the subscription table and the tick counter.
    logic        tbl_valid     [NUM_SLOTS];
    logic [15:0] tbl_port      [NUM_SLOTS];
    logic [15:0] tbl_type      [NUM_SLOTS];
    logic [15:0] tbl_rate      [NUM_SLOTS];
    logic [15:0] tbl_rate_left [NUM_SLOTS];
    logic [15:0] tbl_ticks_left[NUM_SLOTS];
    logic [31:0] tick_model = '0;

    tick_result_t expected_results[$];

    int  mismatch_count  = 0;
    int  commands_sent   = 0;
    int  results_checked = 0;
    int  deliveries_seen = 0;
    int  full_seen       = 0;
    int  not_found_seen  = 0;
    int  cycle_count     = 0;
    int  hold_left       = 0;
    int  recv_wait       = 0;
    bit  send_idle_on    = 1'b1;
    bit  recv_idle_on    = 1'b1;

    periodic_tick_dispatcher #(
        .SLOTS(NUM_SLOTS)
    ) u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser),
        .m_axis_tlast (m_axis_tlast)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            tbl_valid[i]      = 1'b0;
            tbl_port[i]       = '0;
            tbl_type[i]       = '0;
            tbl_rate[i]       = '0;
            tbl_rate_left[i]  = '0;
            tbl_ticks_left[i] = '0;
        end
    end

    function automatic logic [15:0] rand16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic int free_slots();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!tbl_valid[i])
                n++;
        return n;
    endfunction

    // Works out the results of one accepted command and advances the shadow table.
    function automatic void predict_command(logic [1:0] cmd, logic [15:0] port,
                                            logic [15:0] mtype, logic [15:0] rate,
                                            logic [15:0] count);
        tick_result_t batch[$];
        tick_result_t r;
        logic         retire;
        logic [1:0]   st;
        int           n;
        n = 0;
        r = '0;
        case (cmd)
            CMD_TICK:
            begin
                tick_model = tick_model + 32'd1;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (tbl_valid[i])
                    begin
                        retire = 1'b0;
                        if (tbl_ticks_left[i] != 16'd0)
                        begin
                            tbl_ticks_left[i] = tbl_ticks_left[i] - 16'd1;
                            retire = (tbl_ticks_left[i] == 16'd0);
                        end
                        // The rate step comes before retirement, so an expiring slot
                        // still delivers on its final tick.
                        tbl_rate_left[i] = tbl_rate_left[i] - 16'd1;
                        if (tbl_rate_left[i] == 16'd0)
                        begin
                            tbl_rate_left[i] = tbl_rate[i];
                            if (n < RESULT_CAP)
                            begin
                                r             = '0;
                                r.is_delivery = 1'b1;
                                r.status      = STATUS_OK;
                                r.dest_port   = tbl_port[i];
                                r.dest_type   = tbl_type[i];
                                r.tick_value  = tick_model;
                                batch.push_back(r);
                                n++;
                            end
                        end
                        if (retire)
                            tbl_valid[i] = 1'b0;
                    end
                end
                if (n == 0)
                begin
                    r            = '0;
                    r.status     = STATUS_OK;
                    r.tick_value = tick_model;
                    batch.push_back(r);
                end
            end
            CMD_SUBSCRIBE:
            begin
                st = STATUS_FULL;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (!tbl_valid[i])
                    begin
                        tbl_valid[i]      = 1'b1;
                        tbl_port[i]       = port;
                        tbl_type[i]       = mtype;
                        tbl_rate[i]       = rate;
                        tbl_rate_left[i]  = rate;
                        tbl_ticks_left[i] = count;
                        st = STATUS_OK;
                        break;
                    end
                end
                r        = '0;
                r.status = st;
                batch.push_back(r);
            end
            CMD_UNSUBSCRIBE:
            begin
                st = STATUS_NOT_FOUND;
                for (int i = 0; i < NUM_SLOTS; i++)
                begin
                    if (tbl_valid[i] && tbl_port[i] == port && tbl_type[i] == mtype &&
                        tbl_rate[i] == rate)
                    begin
                        tbl_valid[i] = 1'b0;
                        st = STATUS_OK;
                        break;
                    end
                end
                r        = '0;
                r.status = st;
                batch.push_back(r);
            end
            default:
            begin
                r        = '0;
                r.status = STATUS_OK;
                batch.push_back(r);
            end
        endcase
        batch[batch.size() - 1].last = 1'b1;
        foreach (batch[j])
            expected_results.push_back(batch[j]);
    endfunction

    task automatic send_cmd(logic [1:0] cmd, logic [15:0] port, logic [15:0] mtype,
                            logic [15:0] rate, logic [15:0] count);
        int gap;
        @(negedge clk);
        gap = send_idle_on ? $urandom_range(0, 9) : 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {count, rate, mtype, port};
        s_axis_tuser  <= cmd;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        predict_command(cmd, port, mtype, rate, count);
        commands_sent++;
    endtask

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT)
            $display("MISMATCH %s: got 0x%0h, expected 0x%0h (result %0d, t=%0t)",
                     what, got, want, results_checked, $realtime);
    endtask

    // Receiver: a random wait before each transaction, plus any long hold requested.
    initial
    begin : result_receiver
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_left--;
            end
            else if (recv_wait > 0)
            begin
                m_axis_tready <= 1'b0;
                recv_wait--;
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    initial
    begin : result_checker
        tick_result_t got;
        tick_result_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_axis_tvalid && m_axis_tready)
            begin
                got.is_delivery = m_axis_tuser[0];
                got.status      = m_axis_tdata[1:0];
                got.dest_port   = m_axis_tdata[17:2];
                got.dest_type   = m_axis_tdata[33:18];
                got.tick_value  = m_axis_tdata[65:34];
                got.last        = m_axis_tlast;
                if (got.is_delivery === 1'b1)
                    deliveries_seen++;
                if (got.status === STATUS_FULL)
                    full_seen++;
                if (got.status === STATUS_NOT_FOUND)
                    not_found_seen++;
                if (expected_results.size() == 0)
                    report_mismatch("result with none outstanding", got.tick_value, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.is_delivery !== want.is_delivery)
                        report_mismatch("is_delivery", 32'(got.is_delivery),
                                        32'(want.is_delivery));
                    if (got.status !== want.status)
                        report_mismatch("status", 32'(got.status), 32'(want.status));
                    if (got.dest_port !== want.dest_port)
                        report_mismatch("dest_port", 32'(got.dest_port),
                                        32'(want.dest_port));
                    if (got.dest_type !== want.dest_type)
                        report_mismatch("dest_type", 32'(got.dest_type),
                                        32'(want.dest_type));
                    if (got.tick_value !== want.tick_value)
                        report_mismatch("tick_value", got.tick_value, want.tick_value);
                    if (got.last !== want.last)
                        report_mismatch("last", 32'(got.last), 32'(want.last));
                end
                results_checked++;
                recv_wait = recv_idle_on ? $urandom_range(0, 9) : 0;
            end
        end
    end

    initial
    begin : cycle_watchdog
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Run stopped after %0d cycles with %0d results outstanding.",
                 cycle_count, expected_results.size());
        $display("periodic_tick_dispatcher verification failed");
        $finish;
    end

    // Empty ticks, extreme field values, a never-expiring slot, a slot with rate
    // zero, expiry on the final tick, misses, repeated removal and the spare code.
    task automatic test_basic_commands();
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        send_cmd(CMD_SUBSCRIBE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_SUBSCRIBE, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_cmd(CMD_SUBSCRIBE, 16'h1234, 16'h00AA, 16'h0000, 16'h0002);
        send_cmd(CMD_SUBSCRIBE, 16'h8001, 16'h7FFE, 16'h0002, 16'h0003);
        repeat (3)
            send_cmd(CMD_TICK, rand16(), rand16(), rand16(), rand16());
        send_cmd(CMD_UNSUBSCRIBE, 16'h0000, 16'h0000, 16'h0002, 16'h0000);
        send_cmd(CMD_RESERVED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_cmd(CMD_UNSUBSCRIBE, 16'h0000, 16'h0000, 16'h0001, 16'hFFFF);
        send_cmd(CMD_UNSUBSCRIBE, 16'h0000, 16'h0000, 16'h0001, 16'h0000);
        send_cmd(CMD_UNSUBSCRIBE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // Fills every slot, is refused once, then a single tick delivers from all of
    // them and retires them together.
    task automatic test_full_table();
        int k;
        k = 0;
        while (free_slots() > 0)
        begin
            send_cmd(CMD_SUBSCRIBE, 16'(16'h1111 * k), 16'(~k), 16'h0001, 16'h0001);
            k++;
        end
        send_cmd(CMD_SUBSCRIBE, 16'hABCD, 16'h5432, 16'h0003, 16'h0000);
        send_cmd(CMD_TICK, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    endtask

    // The receiver stops for a long stretch while commands keep coming back to back.
    task automatic test_backpressure();
        send_idle_on = 1'b0;
        hold_left    = 300;
        for (int i = 0; i < 4; i++)
            send_cmd(CMD_SUBSCRIBE, rand16(), rand16(), 16'(i + 1), 16'h0006);
        repeat (6)
            send_cmd(CMD_TICK, rand16(), rand16(), rand16(), rand16());
        send_idle_on = 1'b1;
    endtask

    // Mostly meaningful traffic: subscriptions with short rates and expiries,
    // duplicates, removals of live entries, plus near misses and the spare code.
    task automatic test_random_traffic();
        int          pick;
        int          idx;
        int          live[$];
        logic [1:0]  cmd;
        logic [15:0] port;
        logic [15:0] mtype;
        logic [15:0] rate;
        logic [15:0] count;
        for (int k = 0; k < 170; k++)
        begin
            send_idle_on = !(k >= 60 && k < 100);
            recv_idle_on = !(k >= 60 && k < 100);
            live.delete();
            for (int i = 0; i < NUM_SLOTS; i++)
                if (tbl_valid[i])
                    live.push_back(i);
            port  = rand16();
            mtype = rand16();
            rate  = rand16();
            count = rand16();
            pick  = $urandom_range(0, 99);
            if (pick < 32)
                cmd = CMD_TICK;
            else if (pick < 64)
            begin
                cmd = CMD_SUBSCRIBE;
                if (live.size() > 0 && $urandom_range(0, 4) == 0)
                begin
                    idx   = live[$urandom_range(0, live.size() - 1)];
                    port  = tbl_port[idx];
                    mtype = tbl_type[idx];
                    rate  = tbl_rate[idx];
                end
                else if ($urandom_range(0, 9) < 8)
                    rate = 16'($urandom_range(1, 4));
                else if ($urandom_range(0, 1) == 0)
                    rate = 16'h0000;
                if ($urandom_range(0, 9) < 8)
                    count = 16'($urandom_range(0, 6));
            end
            else if (pick < 92)
            begin
                cmd = CMD_UNSUBSCRIBE;
                if (live.size() > 0 && $urandom_range(0, 9) < 7)
                begin
                    idx   = live[$urandom_range(0, live.size() - 1)];
                    port  = tbl_port[idx];
                    mtype = tbl_type[idx];
                    rate  = tbl_rate[idx];
                    // Now and then miss on one field only.
                    case ($urandom_range(0, 7))
                        0: rate  = rate + 16'd1;
                        1: port  = port ^ 16'h0001;
                        2: mtype = mtype ^ 16'h8000;
                        default: ;
                    endcase
                end
            end
            else
                cmd = CMD_RESERVED;
            send_cmd(cmd, port, mtype, rate, count);
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_basic_commands();
        test_full_table();
        test_backpressure();
        test_random_traffic();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d commands; checked %0d results including %0d deliveries.",
                 commands_sent, results_checked, deliveries_seen);
        $display("Saw %0d refusals on a full table, %0d failed removals, %0d ticks in all.",
                 full_seen, not_found_seen, tick_model);
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("periodic_tick_dispatcher verification clean");
        else
            $display("periodic_tick_dispatcher verification failed");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/ptd_pkg.sv
hdl/ptd_ram.sv
hdl/periodic_tick_dispatcher.sv
tb/testbench.sv
